/* hw/rtl/ffur_pkg.sv */
// shared constants, codes and command type of the framed file upload receiver
package ffur_pkg;

    localparam int C_STORE_DEPTH = 64;
    localparam int C_ADDR_W      = $clog2(C_STORE_DEPTH);
    localparam int C_PLEN_W      = 6;
    localparam int C_CMP_W       = (C_ADDR_W > C_PLEN_W) ? C_ADDR_W : C_PLEN_W;

    localparam logic [C_PLEN_W-1:0] C_PLEN_RESET = 6'd32;

    localparam int C_Q_DEPTH = 4;
    localparam int C_Q_PTR_W = $clog2(C_Q_DEPTH);
    localparam int C_Q_CNT_W = $clog2(C_Q_DEPTH + 1);

    // link control bytes
    localparam logic [7:0] C_SOH = 8'h01;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ENQ = 8'h05;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;
    localparam logic [7:0] C_LF  = 8'h0A;

    localparam logic [2:0] C_MODE_WAITING = 3'd0;
    localparam logic [2:0] C_MODE_NAME    = 3'd1;
    localparam logic [2:0] C_MODE_DATA    = 3'd2;
    localparam logic [2:0] C_MODE_DONE    = 3'd3;
    localparam logic [2:0] C_MODE_FAILED  = 3'd4;

    localparam logic [2:0] C_KIND_STATUS = 3'd0;
    localparam logic [2:0] C_KIND_REPLY  = 3'd1;
    localparam logic [2:0] C_KIND_NAME   = 3'd2;
    localparam logic [2:0] C_KIND_DATA   = 3'd3;
    localparam logic [2:0] C_KIND_OPEN   = 3'd4;
    localparam logic [2:0] C_KIND_CLOSE  = 3'd5;

    typedef logic [1:0] t_op;
    localparam t_op C_OP_SINGLE = 2'd0;
    localparam t_op C_OP_STORE  = 2'd1;
    localparam t_op C_OP_DRAIN  = 2'd2;

    typedef struct packed {
        t_op                 op;
        logic [2:0]          kind;
        logic [7:0]          data;
        logic [C_ADDR_W-1:0] addr;
        logic [C_ADDR_W-1:0] count;
        logic                ack_first;
        logic                open_after;
        logic [2:0]          mode;
    } t_cmd;

endpackage

/* hw/rtl/ffur_front.sv */
// front end: accepts received bytes, tracks mode and fill count, issues commands
module ffur_front import ffur_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [C_PLEN_W-1:0] i_cfg_packet_length,
    output logic                o_push,
    output t_cmd                o_cmd,
    input  logic                i_q_full
);

    logic [2:0]          r_mode, n_mode;
    logic [C_ADDR_W-1:0] r_fill, n_fill;
    logic [C_PLEN_W-1:0] r_plen;
    logic                w_accept;
    logic                w_match;
    logic                w_store;
    t_cmd                w_cmd;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_push      = w_accept;
    assign o_cmd       = w_cmd;
    assign w_match     = C_CMP_W'(r_fill) == C_CMP_W'(r_plen);

    always_comb begin
        n_mode           = r_mode;
        n_fill           = r_fill;
        w_store          = 1'b0;
        w_cmd.op         = C_OP_SINGLE;
        w_cmd.kind       = C_KIND_STATUS;
        w_cmd.data       = 8'h00;
        w_cmd.addr       = r_fill;
        w_cmd.count      = r_fill;
        w_cmd.ack_first  = 1'b0;
        w_cmd.open_after = 1'b0;
        if (i_rx_byte == C_SOH) begin
            n_mode = C_MODE_NAME;
            n_fill = '0;
        end else if (i_rx_byte == C_EOT) begin
            n_mode     = C_MODE_DONE;
            w_cmd.kind = C_KIND_CLOSE;
        end else if (i_rx_byte == C_ENQ && r_mode == C_MODE_DATA) begin
            if (w_match) begin
                w_cmd.op        = C_OP_DRAIN;
                w_cmd.kind      = C_KIND_DATA;
                w_cmd.ack_first = 1'b1;
            end else begin
                w_cmd.kind = C_KIND_REPLY;
                w_cmd.data = C_NAK;
            end
            n_fill = '0;
        end else if (i_rx_byte == C_ACK && r_mode == C_MODE_DATA) begin
            // flush; an empty buffer gives a plain status beat
            if (r_fill != '0) begin
                w_cmd.op   = C_OP_DRAIN;
                w_cmd.kind = C_KIND_DATA;
            end
            n_fill = '0;
        end else if (r_mode == C_MODE_NAME) begin
            if (i_rx_byte == C_LF) begin
                w_cmd.op         = C_OP_DRAIN;
                w_cmd.kind       = C_KIND_NAME;
                w_cmd.open_after = 1'b1;
                n_fill           = '0;
                n_mode           = C_MODE_DATA;
            end else begin
                w_store = 1'b1;
            end
        end else if (r_mode == C_MODE_DATA) begin
            w_store = 1'b1;
        end
        if (w_store) begin
            // one slot stays unused: a full buffer drops the byte and fails
            if (r_fill != C_ADDR_W'(C_STORE_DEPTH - 1)) begin
                w_cmd.op   = C_OP_STORE;
                w_cmd.data = i_rx_byte;
                n_fill     = r_fill + C_ADDR_W'(1);
            end else begin
                n_mode = C_MODE_FAILED;
            end
        end
        w_cmd.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= C_MODE_WAITING;
            r_fill <= '0;
            r_plen <= C_PLEN_RESET;
        end else begin
            if (w_accept) begin
                r_mode <= n_mode;
                r_fill <= n_fill;
            end
            if (i_cfg_valid) begin
                r_plen <= i_cfg_packet_length;
            end
        end
    end

`ifndef SYNTHESIS
    a_soh_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_rx_byte == C_SOH) |=> (r_fill == '0 && r_mode == C_MODE_NAME))
        else $error("start of header did not clear the buffer");
`endif

endmodule

/* hw/rtl/ffur_queue.sv */
// short command queue between the front and the back end
module ffur_queue import ffur_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd                 r_slot [C_Q_DEPTH];
    logic [C_Q_PTR_W-1:0] r_wr_ptr;
    logic [C_Q_PTR_W-1:0] r_rd_ptr;
    logic [C_Q_CNT_W-1:0] r_count;

    assign o_full  = r_count == C_Q_CNT_W'(C_Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == C_Q_PTR_W'(C_Q_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + C_Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == C_Q_PTR_W'(C_Q_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + C_Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + C_Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - C_Q_CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count != C_Q_CNT_W'(C_Q_DEPTH)))
        else $error("command queue overflow");
`endif

endmodule

/* hw/rtl/ffur_back.sv */
// back end: owns the byte buffer, executes commands and drives the result beats
module ffur_back import ffur_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic [2:0] o_reader_mode
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SINGLE   = 3'd2;
    localparam logic [2:0] S_ACK      = 3'd3;
    localparam logic [2:0] S_READ     = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;
    localparam logic [2:0] S_OPEN     = 3'd6;

    logic [2:0]          r_state, n_state;
    t_cmd                r_cmd;
    logic [C_ADDR_W-1:0] r_idx, n_idx;
    logic [7:0]          r_mem [C_STORE_DEPTH];
    logic [7:0]          r_rd_data;
    logic                r_out_valid;
    logic [2:0]          r_kind;
    logic [7:0]          r_byte;
    logic                r_last;
    logic [2:0]          r_mode;
    logic                w_slot;
    logic                w_fin;
    logic                w_we;
    logic                w_emit;
    logic [2:0]          w_kind;
    logic [7:0]          w_byte;
    logic                w_last;

    assign w_slot = !r_out_valid || i_out_ready;
    assign w_fin  = (r_idx + C_ADDR_W'(1)) == r_cmd.count;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_emit  = 1'b0;
        w_kind  = r_cmd.kind;
        w_byte  = 8'h00;
        w_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_idx   = '0;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_cmd.op)
                    C_OP_STORE: begin
                        w_we    = 1'b1;
                        n_state = S_SINGLE;
                    end
                    C_OP_DRAIN: begin
                        if (r_cmd.ack_first) begin
                            n_state = S_ACK;
                        end else if (r_cmd.count != '0) begin
                            n_state = S_READ;
                        end else begin
                            n_state = S_OPEN;
                        end
                    end
                    default: begin
                        n_state = S_SINGLE;
                    end
                endcase
            end
            S_SINGLE: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_byte  = (r_cmd.op == C_OP_STORE) ? 8'h00 : r_cmd.data;
                    w_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ACK: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    w_kind = C_KIND_REPLY;
                    w_byte = C_ACK;
                    w_last = (r_cmd.count == '0) && !r_cmd.open_after;
                    if (r_cmd.count != '0) begin
                        n_state = S_READ;
                    end else if (r_cmd.open_after) begin
                        n_state = S_OPEN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                // buffer read data lands in r_rd_data
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    w_byte = r_rd_data;
                    w_last = w_fin && !r_cmd.open_after;
                    if (w_fin) begin
                        n_state = r_cmd.open_after ? S_OPEN : S_IDLE;
                    end else begin
                        n_idx   = r_idx + C_ADDR_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_OPEN: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    w_kind  = C_KIND_OPEN;
                    w_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_cmd.addr] <= r_cmd.data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_emit) begin
            r_kind <= w_kind;
            r_byte <= w_byte;
            r_last <= w_last;
            r_mode <= r_cmd.mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_byte    = r_byte;
    assign o_last        = r_last;
    assign o_reader_mode = r_mode;

`ifndef SYNTHESIS
    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_idx < r_cmd.count))
        else $error("drain index beyond buffered count");
    a_last_ends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == S_IDLE))
        else $error("command continued after its last beat");
`endif

endmodule

/* hw/rtl/framed_file_upload_receiver_top.sv */
// top level of the framed file upload receiver
// usage:
//   input channel: one received link byte per beat on i_rx_byte (i_in_valid / o_in_ready)
//   output channel: result beats with o_kind, o_out_byte, o_last and o_reader_mode
//     (o_out_valid / i_out_ready); o_last marks the final beat caused by one input byte
//   config channel: i_cfg_packet_length written on i_cfg_valid, o_cfg_ready is always high;
//     write it only while no byte is in flight
// timing:
//   the front end classifies a byte in the cycle it is accepted and queues one command
//   (four entries); the back end runs one command at a time
//   a byte with a single result passes the queue and the back end states idle, dispatch
//   and single before o_out_valid rises; a name or data flush adds a read and an emit
//   state per buffered byte, set by the registered read of the byte buffer
// reset: synchronous, active low; mode returns to waiting, the buffer count to zero and
//   packet length to 32; buffer contents are not cleared and need no clearing pass
// stalls: when i_out_ready is low the output beat is held, the back end waits and the
//   queue fills; o_in_ready drops only while the queue is full
module framed_file_upload_receiver_top import ffur_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [C_PLEN_W-1:0] i_cfg_packet_length,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_kind,
    output logic [7:0]          o_out_byte,
    output logic                o_last,
    output logic [2:0]          o_reader_mode
);

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_cmd w_push_cmd;
    t_cmd w_q_cmd;

    ffur_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_packet_length (i_cfg_packet_length),
        .o_push              (w_push),
        .o_cmd               (w_push_cmd),
        .i_q_full            (w_full)
    );

    ffur_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    ffur_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_reader_mode (o_reader_mode)
    );

endmodule

/* test/ffur_checker.sv */
`timescale 1ns / 1ps
// result checker for the framed file upload receiver: predicts every result beat and compares
module ffur_checker import ffur_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [C_PLEN_W-1:0] i_cfg_packet_length,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [2:0]          i_kind,
    input  logic [7:0]          i_out_byte,
    input  logic                i_last,
    input  logic [2:0]          i_reader_mode,
    output int                  o_errors,
    output int                  o_pending
);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
        logic [2:0] mode;
    } t_result_beat;

    t_result_beat expected_beats[$];
    t_result_beat step_beats[$];

    logic [2:0]          rx_mode;
    logic [7:0]          file_buf [C_STORE_DEPTH];
    logic [6:0]          buf_count;
    logic [C_PLEN_W-1:0] packet_len;

    function automatic void add_beat(input logic [2:0] kind, input logic [7:0] data);
        t_result_beat beat;
        beat.kind = kind;
        beat.data = data;
        beat.last = 1'b0;
        beat.mode = C_MODE_WAITING;
        step_beats.push_back(beat);
    endfunction

    function automatic void flush_buf(input logic [2:0] kind);
        int i;
        for (i = 0; i < buf_count; i++) begin
            add_beat(kind, file_buf[i]);
        end
        buf_count = '0;
    endfunction

    // one slot is always kept free, a byte that needs it fails the transfer
    function automatic void keep_byte(input logic [7:0] value);
        if (buf_count < C_STORE_DEPTH - 1) begin
            file_buf[buf_count] = value;
            buf_count           = buf_count + 7'd1;
        end else begin
            rx_mode = C_MODE_FAILED;
        end
    endfunction

    function automatic void predict_rx_byte(input logic [7:0] c);
        int i;
        step_beats.delete();
        if (c == C_SOH) begin
            rx_mode   = C_MODE_NAME;
            buf_count = '0;
        end else if (c == C_EOT) begin
            rx_mode = C_MODE_DONE;
            add_beat(C_KIND_CLOSE, 8'h00);
        end else if (c == C_ENQ && rx_mode == C_MODE_DATA) begin
            if (buf_count == {1'b0, packet_len}) begin
                add_beat(C_KIND_REPLY, C_ACK);
                flush_buf(C_KIND_DATA);
            end else begin
                add_beat(C_KIND_REPLY, C_NAK);
                buf_count = '0;
            end
        end else if (c == C_ACK && rx_mode == C_MODE_DATA) begin
            flush_buf(C_KIND_DATA);
        end else if (rx_mode == C_MODE_NAME) begin
            if (c == C_LF) begin
                flush_buf(C_KIND_NAME);
                add_beat(C_KIND_OPEN, 8'h00);
                rx_mode = C_MODE_DATA;
            end else begin
                keep_byte(c);
            end
        end else if (rx_mode == C_MODE_DATA) begin
            keep_byte(c);
        end

        if (step_beats.size() == 0) add_beat(C_KIND_STATUS, 8'h00);
        step_beats[step_beats.size() - 1].last = 1'b1;
        for (i = 0; i < step_beats.size(); i++) begin
            step_beats[i].mode = rx_mode;
            expected_beats.push_back(step_beats[i]);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result_beat want;
        if (!i_rst_n) begin
            rx_mode    = C_MODE_WAITING;
            buf_count  = '0;
            packet_len = C_PLEN_RESET;
            expected_beats.delete();
            o_errors   = 0;
        end else begin
            // the beat leaving now cannot stem from the byte accepted at this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with none expected: kind %0d, out_byte 0x%02h",
                           i_kind, i_out_byte);
                    o_errors++;
                end else begin
                    want = expected_beats.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, i_kind);
                        o_errors++;
                    end
                    if (i_out_byte !== want.data) begin
                        $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want.data, i_out_byte);
                        o_errors++;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, i_last);
                        o_errors++;
                    end
                    if (i_reader_mode !== want.mode) begin
                        $error("reader_mode mismatch: expected %0d, actual %0d",
                               want.mode, i_reader_mode);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) packet_len = i_cfg_packet_length;
            if (i_in_valid && i_in_ready) predict_rx_byte(i_rx_byte);
        end
        o_pending = expected_beats.size();
    end

endmodule

/* test/tb_framed_file_upload_receiver_top.sv */
`timescale 1ns / 1ps
// testbench top of the framed file upload receiver: stimulus, handshake pacing and verdict
module tb_framed_file_upload_receiver_top;
    import ffur_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [7:0]          i_rx_byte;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [C_PLEN_W-1:0] i_cfg_packet_length;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [2:0]          o_kind;
    logic [7:0]          o_out_byte;
    logic                o_last;
    logic [2:0]          o_reader_mode;

    int fail_count;
    int results_pending;
    int bytes_sent;
    int cur_plen;
    int rx_hold_len;
    bit gaps_on;

    framed_file_upload_receiver_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_packet_length (i_cfg_packet_length),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_out_byte          (o_out_byte),
        .o_last              (o_last),
        .o_reader_mode       (o_reader_mode)
    );

    ffur_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_rx_byte           (i_rx_byte),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_packet_length (i_cfg_packet_length),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_kind              (o_kind),
        .i_out_byte          (o_out_byte),
        .i_last              (o_last),
        .i_reader_mode       (o_reader_mode),
        .o_errors            (fail_count),
        .o_pending           (results_pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("tb_framed_file_upload_receiver_top: done, errors");
        $finish;
    end

    // result side: random stall bursts, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_hold_len) @(negedge i_clk);
                rx_hold_len = 0;
                i_out_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // valid stays up from one beat to the next unless a gap is inserted
    task automatic send_byte(input logic [7:0] value);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (results_pending != 0);
    endtask

    task automatic write_packet_length(input int plen);
        i_cfg_valid         <= 1'b1;
        i_cfg_packet_length <= C_PLEN_W'(plen);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_plen = plen;
    endtask

    function automatic logic [7:0] data_byte();
        logic [7:0] value;
        value = 8'($urandom_range(0, 255));
        if (value == C_SOH || value == C_EOT || value == C_ENQ || value == C_ACK)
            value = value ^ 8'h80;
        return value;
    endfunction

    // name bytes may carry enq and ack, those are stored as name text
    function automatic logic [7:0] name_byte();
        logic [7:0] value;
        value = 8'($urandom_range(0, 255));
        if (value == C_SOH || value == C_EOT || value == C_LF)
            value = value ^ 8'h80;
        return value;
    endfunction

    task automatic send_file();
        int name_len;
        int packets;
        int n;
        int p;
        int pick;
        name_len = $urandom_range(0, 8);
        packets  = (cur_plen > 16) ? 1 : $urandom_range(1, 4);
        send_byte(C_SOH);
        repeat (name_len) send_byte(name_byte());
        send_byte(C_LF);
        for (p = 0; p < packets; p++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                n = cur_plen;
            else if (pick < 8)
                n = $urandom_range(0, cur_plen + 2);
            else
                n = $urandom_range(0, 6);
            repeat (n) send_byte(data_byte());
            if (pick < 8)
                send_byte(C_ENQ);
            else
                send_byte(C_ACK);
            if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)));
        end
        // some transfers are cut off before the closing eot
        if ($urandom_range(0, 4) != 0) send_byte(C_EOT);
    endtask

    initial begin
        int ph;
        int phase_start;
        int phase_plen[6];
        phase_plen = '{1, 6, 31, 2, 13, 4};

        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_rx_byte           = 8'h00;
        i_cfg_valid         = 1'b0;
        i_cfg_packet_length = '0;
        i_out_ready         = 1'b0;
        bytes_sent          = 0;
        cur_plen            = 32;
        rx_hold_len         = 0;
        gaps_on             = 1'b1;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_packet_length(3);
        // idle link: everything is ignored
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(C_ACK);
        send_byte(C_ENQ);
        send_byte(C_LF);
        // file name with zero, enq and ack bytes in it
        send_byte(C_SOH);
        send_byte(8'h00);
        send_byte(C_ENQ);
        send_byte(C_ACK);
        send_byte(8'hFF);
        send_byte(C_LF);
        // flush of an empty buffer, then a real flush
        send_byte(C_ACK);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(C_ACK);
        // full packet acknowledged, short one refused
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(C_ENQ);
        send_byte(8'h5A);
        send_byte(C_ENQ);
        // eot with data left, then eot in name and done modes
        send_byte(8'h33);
        send_byte(C_EOT);
        send_byte(8'h41);
        send_byte(C_SOH);
        send_byte(C_EOT);
        send_byte(C_EOT);

        // zero packet length: only an empty buffer is acknowledged
        wait_results_drained();
        write_packet_length(0);
        send_byte(C_SOH);
        send_byte(C_LF);
        send_byte(C_ENQ);
        send_byte(8'h12);
        send_byte(C_ENQ);
        send_byte(C_EOT);

        // longest packet, then overflow into failed and recovery by soh
        wait_results_drained();
        write_packet_length(63);
        send_byte(C_SOH);
        send_byte(C_LF);
        repeat (63) send_byte(data_byte());
        send_byte(C_ENQ);
        repeat (64) send_byte(data_byte());
        send_byte(C_ENQ);
        send_byte(8'h77);
        send_byte(C_SOH);
        send_byte(C_EOT);

        for (ph = 0; ph < 6; ph++) begin
            wait_results_drained();
            write_packet_length(phase_plen[ph]);
            if (ph == 5) gaps_on = 1'b0;
            // result side holds off while bytes keep coming, so the input stalls
            if (ph == 1) rx_hold_len = 150;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 20) begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                else
                    send_file();
                if ($urandom_range(0, 7) == 0) wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && results_pending == 0)
            $display("tb_framed_file_upload_receiver_top: done, clean");
        else
            $display("tb_framed_file_upload_receiver_top: done, errors");
        $finish;
    end

endmodule
